>>> hw/rtl/tsgd_pkg.sv
package tsgd_pkg;

    // Field widths
    localparam int unsigned PadW    = 8;
    localparam int unsigned SumW    = 10;   // holds 3 * 255
    localparam int unsigned DvdW    = 15;   // holds 255 * 100
    localparam int unsigned PosW    = 8;    // centroid in -100..100
    localparam int unsigned GestW   = 3;
    localparam int unsigned DivSteps = DvdW;
    localparam int unsigned CntW    = $clog2(DivSteps);

    // Centroid scale factor
    localparam logic [DvdW-1:0] PosScale = 15'd100;

    // Gesture codes
    localparam logic [GestW-1:0] G_NONE    = 3'd0;
    localparam logic [GestW-1:0] G_PRESS   = 3'd1;
    localparam logic [GestW-1:0] G_RELEASE = 3'd2;
    localparam logic [GestW-1:0] G_FWD     = 3'd3;
    localparam logic [GestW-1:0] G_BACK    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOUCH_THR = 2'd0;
    localparam logic [1:0] CFG_SWIPE_THR = 2'd1;

    // Configuration reset values
    localparam logic [PadW-1:0] TouchThrReset = 8'd1;
    localparam logic [PadW-1:0] SwipeThrReset = 8'd40;

    // Touch tracking phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TOUCHED = 2'd1,
        PH_SWIPING = 2'd2
    } t_phase;

    // Sequencer states
    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_DIV  = 2'd1,
        CS_DONE = 2'd2
    } t_ctrl_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture pads, start a division
        logic step;     // one restoring division step
        logic commit;   // update gesture state, load output word
    } t_dp_cmd;

endpackage

>>> hw/rtl/touch_slider_gesture_detector.sv
// Three-pad touch slider gesture detector. Each input word is one poll of the
// slider (left, middle, right intensities); each poll yields exactly one output
// word carrying a gesture code: none, press, release, swipe forward or swipe
// backward. The centroid (right - left) * 100 / sum is formed by a restoring
// divider that retires one quotient bit per cycle. A poll is captured at the
// edge that accepts it, runs 15 divide steps, and then updates the gesture
// state and loads its result word; a new poll is accepted only after that
// update. The output word is registered, so the next poll is taken while a
// result still waits; that poll then holds in its update step until the
// waiting word is taken. Thresholds are written through the configuration
// channel (index 0 touch threshold, 1 swipe threshold; other indexes
// ignored) and should only be changed while no poll is in flight.
module touch_slider_gesture_detector
    import tsgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] pad_left, [15:8] pad_middle, [23:16] pad_right
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] gesture, [7:3] zero
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_dp_cmd          cmd;
    logic [GestW-1:0] gesture;
    logic [PadW-1:0]  r_touch_thr;
    logic [PadW-1:0]  r_swipe_thr;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_thr <= TouchThrReset;
            r_swipe_thr <= SwipeThrReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOUCH_THR: r_touch_thr <= i_cfg_data;
                CFG_SWIPE_THR: r_swipe_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tsgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    tsgd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_pad_left   (s_axis_tdata[7:0]),
        .i_pad_middle (s_axis_tdata[15:8]),
        .i_pad_right  (s_axis_tdata[23:16]),
        .i_touch_thr  (r_touch_thr),
        .i_swipe_thr  (r_swipe_thr),
        .o_gesture    (gesture)
    );

    assign m_axis_tdata = {5'd0, gesture};

endmodule

>>> hw/rtl/tsgd_ctrl.sv
module tsgd_ctrl
    import tsgd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_ctrl_state r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic last_step;

    assign last_step = (r_cnt == CntW'(DivSteps - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE: begin
                if (i_in_valid) n_state = CS_DIV;
            end
            CS_DIV: begin
                if (last_step) n_state = CS_DONE;
            end
            CS_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = CS_IDLE;
            end
            default: n_state = CS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            CS_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            CS_DIV: begin
                o_cmd.step = 1'b1;
            end
            CS_DONE: begin
                o_cmd.commit = !r_out_valid || i_out_ready;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Step counter and output word valid
    always_comb begin
        n_cnt = r_cnt;
        if (o_cmd.load) n_cnt = '0;
        else if (o_cmd.step) n_cnt = r_cnt + CntW'(1);

        n_out_valid = r_out_valid;
        if (o_cmd.commit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/tsgd_dp.sv
module tsgd_dp
    import tsgd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [PadW-1:0]  i_pad_left,
    input  logic [PadW-1:0]  i_pad_middle,
    input  logic [PadW-1:0]  i_pad_right,
    input  logic [PadW-1:0]  i_touch_thr,
    input  logic [PadW-1:0]  i_swipe_thr,
    output logic [GestW-1:0] o_gesture
);

    logic [SumW-1:0]  r_sum;
    logic             r_neg;
    logic             r_touched;
    logic [SumW-1:0]  r_rem;
    logic [DvdW-1:0]  r_quo;
    t_phase           r_phase, n_phase;
    logic [PosW-1:0]  r_start, n_start;
    logic [GestW-1:0] r_gesture, n_gesture;

    logic [PadW:0]   diff;
    logic [PadW-1:0] diff_abs;
    logic [PadW-1:0] peak;
    logic [SumW:0]   rem_sh;
    logic            rem_ge;
    logic [PosW-1:0] quo_lo;
    logic [PosW-1:0] pos;
    logic [PosW:0]   delta;
    logic [PosW:0]   thr_pos;
    logic [PosW:0]   thr_neg;
    logic            swipe_fwd;
    logic            swipe_back;

    // Signed pad difference and peak intensity
    always_comb begin
        diff     = {1'b0, i_pad_right} - {1'b0, i_pad_left};
        diff_abs = diff[PadW] ? PadW'(-diff) : diff[PadW-1:0];
        peak     = i_pad_left;
        if (i_pad_middle > peak) peak = i_pad_middle;
        if (i_pad_right > peak) peak = i_pad_right;
    end

    // One restoring division step
    always_comb begin
        rem_sh = {r_rem, r_quo[DvdW-1]};
        rem_ge = rem_sh >= {1'b0, r_sum};
    end

    // Capture operands, then iterate the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum     <= SumW'(i_pad_left) + SumW'(i_pad_middle) + SumW'(i_pad_right);
            r_neg     <= diff[PadW];
            r_touched <= peak >= i_touch_thr;
            r_rem     <= '0;
            r_quo     <= DvdW'(diff_abs) * PosScale;
        end else if (i_cmd.step) begin
            r_rem <= rem_ge ? SumW'(rem_sh - {1'b0, r_sum}) : rem_sh[SumW-1:0];
            r_quo <= {r_quo[DvdW-2:0], rem_ge};
        end
    end

    // Signed centroid and displacement from the press position
    always_comb begin
        quo_lo = r_quo[PosW-1:0];
        if (r_sum == '0) pos = '0;
        else if (r_neg) pos = -quo_lo;
        else pos = quo_lo;
        delta      = {pos[PosW-1], pos} - {r_start[PosW-1], r_start};
        thr_pos    = {1'b0, i_swipe_thr};
        thr_neg    = -thr_pos;
        swipe_fwd  = $signed(delta) > $signed(thr_pos);
        swipe_back = $signed(delta) < $signed(thr_neg);
    end

    // Gesture state update
    always_comb begin
        n_phase   = r_phase;
        n_start   = r_start;
        n_gesture = G_NONE;
        case (r_phase)
            PH_TOUCHED: begin
                if (!r_touched) begin
                    n_phase   = PH_IDLE;
                    n_gesture = G_RELEASE;
                end else if (swipe_fwd) begin
                    n_phase   = PH_SWIPING;
                    n_gesture = G_FWD;
                end else if (swipe_back) begin
                    n_phase   = PH_SWIPING;
                    n_gesture = G_BACK;
                end
            end
            PH_SWIPING: begin
                if (!r_touched) begin
                    n_phase   = PH_IDLE;
                    n_gesture = G_RELEASE;
                end
            end
            default: begin
                if (r_touched) begin
                    n_phase   = PH_TOUCHED;
                    n_start   = pos;
                    n_gesture = G_PRESS;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_start <= '0;
        end else if (i_cmd.commit) begin
            r_phase <= n_phase;
            r_start <= n_start;
        end
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_gesture <= n_gesture;
    end

    assign o_gesture = r_gesture;

endmodule

>>> hw/rtl/tsgd_checker.sv
module tsgd_checker
    import tsgd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Gesture code stays within the defined set, padding stays clear
    a_gesture_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == G_NONE || m_axis_tdata[2:0] == G_PRESS
            || m_axis_tdata[2:0] == G_RELEASE || m_axis_tdata[2:0] == G_FWD
            || m_axis_tdata[2:0] == G_BACK) && (m_axis_tdata[7:3] == 5'd0))
        else $error("gesture code out of range");

    // One poll in flight: no new word right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted while divider busy");

    // Divider latency: no result appears right after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 !$rose(m_axis_tvalid))
        else $error("result ahead of divider latency");

    // Stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind touch_slider_gesture_detector tsgd_checker u_tsgd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/touch_slider_gesture_detector_tb.sv
module touch_slider_gesture_detector_tb;
    import tsgd_pkg::*;

    localparam int unsigned TimeoutCycles = 200000;
    localparam int unsigned DrainCycles   = 40;
    localparam int unsigned PollsPerChunk = 33;
    localparam int unsigned ChunksPerRun  = 4;

    // Indexes with no register behind them
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] pad_left, [15:8] pad_middle, [23:16] pad_right
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [2:0] gesture, [7:3] zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    // Shadow of the block's configuration and gesture state
    logic [PadW-1:0]        touch_thr_q = TouchThrReset;
    logic [PadW-1:0]        swipe_thr_q = SwipeThrReset;
    t_phase                 phase_q = PH_IDLE;
    logic signed [PosW-1:0] start_pos_q = '0;

    logic [GestW-1:0] gesture_q [$];
    int               n_errors = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;

    touch_slider_gesture_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Compute the gesture for one poll and advance the shadow state
    function automatic logic [GestW-1:0] predict_gesture(input logic [PadW-1:0] l,
                                                         input logic [PadW-1:0] m,
                                                         input logic [PadW-1:0] r);
        int               sum;
        int               pos;
        int               delta;
        int               thr;
        logic [PadW-1:0]  peak;
        logic             touched;
        logic [GestW-1:0] g;
        sum = l + m + r;
        // signed int division truncates toward zero
        pos = (sum == 0) ? 0 : ((int'(r) - int'(l)) * 100) / sum;
        peak = l;
        if (m > peak) peak = m;
        if (r > peak) peak = r;
        touched = (peak >= touch_thr_q);
        g = G_NONE;
        case (phase_q)
            PH_TOUCHED: begin
                if (!touched) begin
                    phase_q = PH_IDLE;
                    g = G_RELEASE;
                end else begin
                    delta = pos - int'(start_pos_q);
                    thr = int'(swipe_thr_q);
                    if (delta > thr) begin
                        phase_q = PH_SWIPING;
                        g = G_FWD;
                    end else if (delta < -thr) begin
                        phase_q = PH_SWIPING;
                        g = G_BACK;
                    end
                end
            end
            PH_SWIPING: begin
                if (!touched) begin
                    phase_q = PH_IDLE;
                    g = G_RELEASE;
                end
            end
            default: begin
                if (touched) begin
                    phase_q = PH_TOUCHED;
                    start_pos_q = pos[PosW-1:0];
                    g = G_PRESS;
                end
            end
        endcase
        return g;
    endfunction

    // Offer one poll word after a random gap and record its gesture once taken
    task automatic send_poll(input logic [PadW-1:0] l, input logic [PadW-1:0] m,
                             input logic [PadW-1:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, m, l};
        do @(posedge i_clk); while (!s_axis_tready);
        gesture_q.push_back(predict_gesture(l, m, r));
    endtask

    // Drop the input valid and wait for every outstanding gesture word
    task automatic drain_polls();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (gesture_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; the caller lowers the valid after the last one
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TOUCH_THR: touch_thr_q = data;
            CFG_SWIPE_THR: swipe_thr_q = data;
            default: ;
        endcase
    endtask

    // Reprogram both thresholds with the block idle, plus a write to a spare index
    task automatic set_thresholds(input logic [7:0] touch, input logic [7:0] swipe);
        drain_polls();
        write_reg(CFG_TOUCH_THR, touch);
        write_reg(CFG_SWIPE_THR, swipe);
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom_range(255)));
        i_cfg_valid <= 1'b0;
    endtask

    // Press, swipe both ways, exact threshold and rounding toward zero at reset config
    task automatic test_default_config();
        send_poll(8'd0, 8'd0, 8'd0);
        send_poll(8'd0, 8'd255, 8'd0);
        send_poll(8'd0, 8'd60, 8'd40);
        send_poll(8'd0, 8'd59, 8'd41);
        send_poll(8'd255, 8'd255, 8'd255);
        send_poll(8'd0, 8'd0, 8'd0);
        send_poll(8'd255, 8'd0, 8'd0);
        send_poll(8'd0, 8'd0, 8'd255);
        send_poll(8'd0, 8'd0, 8'd0);
        send_poll(8'd2, 8'd1, 8'd0);
        send_poll(8'd1, 8'd1, 8'd0);
        send_poll(8'd0, 8'd0, 8'd0);
        send_poll(8'd0, 8'd0, 8'd255);
        send_poll(8'd255, 8'd0, 8'd0);
        send_poll(8'd0, 8'd0, 8'd0);
    endtask

    // Zero touch threshold, zero swipe threshold, and the top of both ranges
    task automatic test_threshold_extremes();
        set_thresholds(8'd0, 8'd0);
        send_poll(8'd0, 8'd0, 8'd0);
        send_poll(8'd0, 8'd1, 8'd1);
        set_thresholds(8'd255, 8'd200);
        send_poll(8'd0, 8'd0, 8'd0);
        send_poll(8'd255, 8'd0, 8'd0);
        send_poll(8'd0, 8'd0, 8'd255);
        send_poll(8'd1, 8'd0, 8'd255);
        send_poll(8'd0, 8'd0, 8'd254);
        set_thresholds(8'd1, 8'd255);
        send_poll(8'd255, 8'd0, 8'd0);
        send_poll(8'd0, 8'd0, 8'd255);
    endtask

    // Mostly touch and release words around the threshold, some raw noise
    task automatic send_random_poll();
        logic [PadW-1:0] pad [3];
        int              kind;
        int              hot;
        kind = $urandom_range(99);
        for (int i = 0; i < 3; i++) pad[i] = 8'($urandom_range(255));
        if (kind < 25 && touch_thr_q != 0) begin
            for (int i = 0; i < 3; i++) pad[i] = 8'($urandom_range(touch_thr_q - 1, 0));
        end else if (kind < 85) begin
            hot = $urandom_range(2);
            pad[hot] = 8'($urandom_range(255, touch_thr_q));
        end
        send_poll(pad[0], pad[1], pad[2]);
    endtask

    // Random gesture traffic over several threshold settings
    task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
        logic [7:0] touch;
        logic [7:0] swipe;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        for (int c = 0; c < ChunksPerRun; c++) begin
            case ($urandom_range(7))
                0: touch = 8'd0;
                1: touch = 8'd255;
                2: touch = 8'd1;
                default: touch = 8'($urandom_range(128, 1));
            endcase
            case ($urandom_range(7))
                0: swipe = 8'd0;
                1: swipe = 8'd200;
                2: swipe = 8'd255;
                default: swipe = 8'($urandom_range(100));
            endcase
            set_thresholds(touch, swipe);
            for (int n = 0; n < PollsPerChunk; n++) send_random_poll();
        end
    endtask

    // Stall the output at random and check each gesture word against the oldest expectation
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (gesture_q.size() == 0) begin
                $error("gesture: unexpected word, expected none, actual %0d",
                       m_axis_tdata[GestW-1:0]);
                n_errors++;
            end else if (m_axis_tdata[GestW-1:0] !== gesture_q[0]) begin
                $error("gesture: expected %0d, actual %0d", gesture_q[0],
                       m_axis_tdata[GestW-1:0]);
                n_errors++;
                void'(gesture_q.pop_front());
            end else begin
                void'(gesture_q.pop_front());
            end
        end
    end

    initial begin
        send_idle_pct = 13;
        recv_idle_pct = 86;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_threshold_extremes();
        test_random_traffic(13, 86);
        test_random_traffic(86, 13);
        test_random_traffic(0, 0);
        drain_polls();
        repeat (DrainCycles) @(posedge i_clk);
        if (n_errors == 0 && gesture_q.size() == 0) begin
            $display("touch_slider_gesture_detector_tb: PASS");
        end else begin
            $display("touch_slider_gesture_detector_tb: FAIL");
        end
        $finish;
    end

    // End a hung run
    initial begin
        repeat (TimeoutCycles) @(posedge i_clk);
        $display("touch_slider_gesture_detector_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tsgd_pkg.sv
hw/rtl/tsgd_ctrl.sv
hw/rtl/tsgd_dp.sv
hw/rtl/touch_slider_gesture_detector.sv
hw/rtl/tsgd_checker.sv
bench/touch_slider_gesture_detector_tb.sv
